### src/calb_pkg.sv
`default_nettype none

package calb_pkg;

	// Field widths
	localparam int unsigned POS_W   = 64;
	localparam int unsigned LIMIT_W = 15;
	localparam int unsigned BYTE_W  = 8;

	// Remainder is built one dividend bit per cycle
	localparam int unsigned DIV_STEPS = POS_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

	// Item modes
	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	// Result status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_PAST_END = 1'b1;

	// Top level sequencer
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_MEM   = 5'b01000,
		ST_OUT   = 5'b10000
	} calb_state_t;

endpackage

`default_nettype wire

### src/calb_divmod.sv
`default_nettype none

// Bit-serial restoring remainder: dividend modulo divisor, one dividend bit per cycle.
module calb_divmod (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [calb_pkg::POS_W-1:0]        dividend,
	input  wire logic [calb_pkg::LIMIT_W-1:0]      divisor,
	output logic                                   done,
	output logic [calb_pkg::LIMIT_W-1:0]           remainder
);

	logic                               run_q;
	logic [calb_pkg::CNT_W-1:0]         cnt_q;
	logic [calb_pkg::POS_W-1:0]         sr_q;
	logic [calb_pkg::LIMIT_W-1:0]       div_q;
	logic [calb_pkg::LIMIT_W-1:0]       rem_q;
	logic [calb_pkg::LIMIT_W:0]         shifted;
	logic [calb_pkg::LIMIT_W:0]         rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, sr_q[calb_pkg::POS_W-1]};
		if (shifted >= {1'b0, div_q}) begin
			rem_next = shifted - {1'b0, div_q};
		end else begin
			rem_next = shifted;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			sr_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			sr_q  <= {sr_q[calb_pkg::POS_W-2:0], 1'b0};
			rem_q <= rem_next[calb_pkg::LIMIT_W-1:0];
		end
	end

	// Last step is taken at the edge that ends this cycle
	assign done      = run_q && (cnt_q == calb_pkg::CNT_W'(calb_pkg::DIV_STEPS - 1));
	assign remainder = rem_q;

endmodule

`default_nettype wire

### src/capped_append_log_buffer_core.sv
`default_nettype none

// Result strobe (done) follows the divide and memory steps after start is accepted.
// Items are paced by the bit-serial position modulo limit (64 steps).
// start may be taken in the cycle that shows a result, so items can run back to back.
// Reset: async active low; a clearing sweep then zeroes every store entry, with busy high.
// Limit writes are taken at any time, including during the sweep. Results cannot be stalled.
module capped_append_log_buffer_core #(
	parameter int unsigned STORE_DEPTH = 16384
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration
	input  wire logic                            limit_we,
	input  wire logic [calb_pkg::LIMIT_W-1:0]    limit_wdata,
	// Command
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            mode,
	input  wire logic [calb_pkg::POS_W-1:0]      position,
	input  wire logic [calb_pkg::BYTE_W-1:0]     data_in,
	// Result
	output logic                                 done,
	output logic [calb_pkg::BYTE_W-1:0]          data_out,
	output logic                                 status,
	output logic                                 repositioned,
	output logic [calb_pkg::POS_W-1:0]           log_length
);

	localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	calb_pkg::calb_state_t              state_q;
	logic [calb_pkg::LIMIT_W-1:0]       limit_q;
	logic [calb_pkg::LIMIT_W-1:0]       eff_limit;
	logic [calb_pkg::LIMIT_W-1:0]       eff_q;
	logic [calb_pkg::POS_W-1:0]         wp_q;
	logic [calb_pkg::POS_W-1:0]         diff_q;
	logic                               mode_q;
	logic [calb_pkg::BYTE_W-1:0]        data_q;
	logic                               repos_q;
	logic                               past_q;
	logic                               in_range_q;
	logic [AW-1:0]                      clr_q;
	logic                               accept;
	logic                               div_done;
	logic [calb_pkg::LIMIT_W-1:0]       rem;
	logic [AW+calb_pkg::LIMIT_W-1:0]    slot_wide;
	logic [AW-1:0]                      slot;
	logic [calb_pkg::POS_W:0]           sub_wide;
	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic [calb_pkg::BYTE_W-1:0]        mem_wdata;
	logic [calb_pkg::BYTE_W-1:0]        mem_q [STORE_DEPTH];
	logic [calb_pkg::BYTE_W-1:0]        rdata_q;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= calb_pkg::LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// Effective limit: zero acts as one, capped at the store depth
	always_comb begin
		if (limit_q == '0) begin
			eff_limit = calb_pkg::LIMIT_W'(1);
		end else if (32'(limit_q) > 32'(STORE_DEPTH)) begin
			eff_limit = calb_pkg::LIMIT_W'(STORE_DEPTH);
		end else begin
			eff_limit = limit_q;
		end
	end

	// Handshake
	assign busy   = !((state_q == calb_pkg::ST_IDLE) || (state_q == calb_pkg::ST_OUT));
	assign accept = start && !busy;

	// Read distance behind the write position; the borrow flags a position past it
	assign sub_wide = {1'b0, wp_q} - {1'b0, position};

	// Slot index from the serial remainder
	calb_divmod u_divmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (position),
		.divisor   (eff_limit),
		.done      (div_done),
		.remainder (rem)
	);

	assign slot_wide = (AW + calb_pkg::LIMIT_W)'(rem);
	assign slot      = slot_wide[AW-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= calb_pkg::ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
		end else begin
			case (state_q)
				calb_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(STORE_DEPTH - 1)) begin
						state_q <= calb_pkg::ST_IDLE;
					end
				end
				calb_pkg::ST_IDLE, calb_pkg::ST_OUT: begin
					if (accept) begin
						state_q <= calb_pkg::ST_DIV;
						if (mode == calb_pkg::MODE_APPEND) begin
							wp_q <= position;
						end
					end else begin
						state_q <= calb_pkg::ST_IDLE;
					end
				end
				calb_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= calb_pkg::ST_MEM;
					end
				end
				calb_pkg::ST_MEM: begin
					state_q <= calb_pkg::ST_OUT;
					if (mode_q == calb_pkg::MODE_APPEND) begin
						wp_q <= wp_q + 1'b1;
					end
				end
				default: begin
					state_q <= calb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Item fields and per-item flags
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			data_q  <= data_in;
			eff_q   <= eff_limit;
			diff_q  <= sub_wide[calb_pkg::POS_W-1:0];
			past_q  <= (mode == calb_pkg::MODE_READ) &&
				(sub_wide[calb_pkg::POS_W] || (sub_wide == '0));
			repos_q <= (mode == calb_pkg::MODE_APPEND) && (position != wp_q);
		end
		if (state_q == calb_pkg::ST_DIV) begin
			in_range_q <= diff_q <= calb_pkg::POS_W'(eff_q);
		end
	end

	// Store write port: clearing sweep or append
	always_comb begin
		if (state_q == calb_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == calb_pkg::ST_MEM) && (mode_q == calb_pkg::MODE_APPEND);
			mem_waddr = slot;
			mem_wdata = data_q;
		end
	end

	// Byte store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[slot];
	end

	// Result
	assign done         = (state_q == calb_pkg::ST_OUT);
	assign status       = past_q ? calb_pkg::STATUS_PAST_END : calb_pkg::STATUS_OK;
	assign data_out     = ((mode_q == calb_pkg::MODE_READ) && !past_q && in_range_q) ?
		rdata_q : '0;
	assign repositioned = repos_q;
	assign log_length   = wp_q;

`ifndef NO_ASSERTIONS
	// Remainder finishes only while the sequencer waits for it
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == calb_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	// A result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// Past-end reads return no data
	a_past_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (data_out == '0))
		else $error("past-end read returned data");

	// Reposition flag only on appends, which never report past-end
	a_repos_append: assert property (@(posedge clk) disable iff (!arst_n)
		(done && repositioned) |-> (!status && (mode_q == calb_pkg::MODE_APPEND)))
		else $error("reposition flag on a read");

	// An append advances the write position by one in the memory step
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == calb_pkg::ST_MEM) && (mode_q == calb_pkg::MODE_APPEND)) |=>
		(wp_q == $past(wp_q) + 1'b1))
		else $error("write position did not advance on append");
`endif

endmodule

`default_nettype wire
